// ----- rtl/spl_pkg.sv -----
package spl_pkg;

	localparam int DATA_W = 32;
	localparam int IDX_W = 8;
	localparam int KC_W = 9;
	localparam int S_TDATA_W = 232;
	localparam int M_TDATA_W = 48;
	localparam int ADDR_W = 3;
	localparam int MIN_KNOTS = 2;
	localparam int WIDE_W = 48;
	localparam logic [WIDE_W-2:0] WIDE_MAG = '1;

	localparam logic [1:0] OP_LOAD = 2'd0;
	localparam logic [1:0] OP_EVAL = 2'd1;
	localparam logic [1:0] OP_INTEG = 2'd2;

	localparam logic REG_KNOT_COUNT = 1'b0;

	typedef enum logic [1:0] {
		K_LOAD,
		K_EVAL,
		K_INTEG
	} cmd_kind_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] slope;
		logic signed [DATA_W-1:0] square;
		logic signed [DATA_W-1:0] cubic;
		logic signed [DATA_W-1:0] value;
		logic signed [DATA_W-1:0] position;
	} entry_t;

	typedef struct packed {
		cmd_kind_t kind;
		logic [IDX_W-1:0] idx;
		entry_t ent;
		logic signed [DATA_W-1:0] q1;
		logic signed [DATA_W-1:0] q2;
	} cmd_t;

endpackage

// ----- rtl/spl_ram.sv -----
module spl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/spl_mul.sv -----
module spl_mul import spl_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [DATA_W:0]   a,
	input  logic signed [WIDE_W-1:0] b,
	output logic                     done,
	output logic signed [WIDE_W-1:0] p,
	output logic                     ov
);

	localparam int DIG_W = 16;
	localparam int ACC_W = DATA_W + WIDE_W;

	typedef enum logic [2:0] {
		M_IDLE = 3'b001,
		M_RUN  = 3'b010,
		M_FIN  = 3'b100
	} mstate_t;

	mstate_t state_q;
	logic [DATA_W-1:0] ua_q;
	logic [WIDE_W-1:0] ub_q;
	logic neg_q;
	logic [ACC_W-1:0] acc_q;
	logic [1:0] cnt_q;

	logic [DATA_W:0] a_mag;
	logic [WIDE_W-1:0] b_mag;
	logic [ACC_W-1:0] rounded;
	logic [ACC_W-DIG_W-1:0] r;
	logic ovr;
	logic [WIDE_W-2:0] mag;

	always_comb begin
		a_mag = a[DATA_W] ? -a : a;
		b_mag = b[WIDE_W-1] ? -b : b;
		rounded = acc_q + ACC_W'(32'h8000);
		r = rounded[ACC_W-1:DIG_W];
		ovr = |r[ACC_W-DIG_W-1:WIDE_W-1];
		mag = ovr ? WIDE_MAG : r[WIDE_W-2:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				M_IDLE: begin
					if (start) begin
						state_q <= M_RUN;
					end
				end
				M_RUN: begin
					if (cnt_q == 2'd2) begin
						state_q <= M_FIN;
					end
				end
				M_FIN: begin
					done <= 1'b1;
					state_q <= M_IDLE;
				end
				default: state_q <= M_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			M_IDLE: begin
				ua_q <= a_mag[DATA_W-1:0];
				ub_q <= b_mag;
				neg_q <= a[DATA_W] != b[WIDE_W-1];
				acc_q <= '0;
				cnt_q <= '0;
			end
			M_RUN: begin
				acc_q <= {acc_q[ACC_W-DIG_W-1:0], {DIG_W{1'b0}}}
					+ ACC_W'(ua_q * ub_q[WIDE_W-1 -: DIG_W]);
				ub_q <= ub_q << DIG_W;
				cnt_q <= cnt_q + 2'd1;
			end
			M_FIN: begin
				p <= neg_q ? -{1'b0, mag} : {1'b0, mag};
				ov <= ovr;
			end
			default: begin
				cnt_q <= '0;
			end
		endcase
	end

endmodule

// ----- rtl/spl_front.sv -----
module spl_front import spl_pkg::*; #(
	parameter int MAX_KNOTS = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,
	input  logic [1:0]           s_tuser,
	output logic                 cmd_valid,
	output cmd_t                 cmd,
	input  logic                 cmd_pop
);

	cmd_t q_mem [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	cmd_t incoming;
	logic keep, push;

	always_comb begin
		incoming.idx = s_tdata[7:0];
		incoming.ent.position = s_tdata[39:8];
		incoming.ent.value = s_tdata[71:40];
		incoming.ent.cubic = s_tdata[103:72];
		incoming.ent.square = s_tdata[135:104];
		incoming.ent.slope = s_tdata[167:136];
		incoming.q1 = s_tdata[199:168];
		incoming.q2 = s_tdata[231:200];
		incoming.kind = K_LOAD;
		keep = 1'b0;
		case (s_tuser)
			OP_LOAD: begin
				incoming.kind = K_LOAD;
				keep = 32'(s_tdata[7:0]) < 32'(MAX_KNOTS);
			end
			OP_EVAL: begin
				incoming.kind = K_EVAL;
				keep = 1'b1;
			end
			OP_INTEG: begin
				incoming.kind = K_INTEG;
				keep = 1'b1;
			end
			default: keep = 1'b0;
		endcase
	end

	assign s_tready = cnt_q != 2'd2;
	assign push = s_tvalid && s_tready && keep;
	assign cmd_valid = cnt_q != 2'd0;
	assign cmd = q_mem[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (cmd_pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, cmd_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wp_q] <= incoming;
		end
	end

endmodule

// ----- rtl/spl_back.sv -----
module spl_back import spl_pkg::*; #(
	parameter int MAX_KNOTS = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [KC_W-1:0]      kc,
	input  logic                 cmd_valid,
	input  cmd_t                 cmd,
	output logic                 cmd_pop,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata
);

	localparam int AW = $clog2(MAX_KNOTS);
	localparam int NW = $clog2(MAX_KNOTS + 1);
	localparam logic [DATA_W-1:0] RECIP3 = 32'hAAAAAAAB;

	typedef enum logic [10:0] {
		ST_IDLE = 11'b00000000001,
		ST_SRD  = 11'b00000000010,
		ST_SCMP = 11'b00000000100,
		ST_SEG  = 11'b00000001000,
		ST_NRD  = 11'b00000010000,
		ST_NLAT = 11'b00000100000,
		ST_ERD  = 11'b00001000000,
		ST_ELAT = 11'b00010000000,
		ST_STRT = 11'b00100000000,
		ST_HRN  = 11'b01000000000,
		ST_FIN  = 11'b10000000000
	} bstate_t;

	bstate_t state_q;
	logic eval_q, flip_q, phase_q, term_q, go_q, ov_q;
	logic signed [DATA_W-1:0] lo_q, hi_q, npos_q, cub4_q, sq3_q, sl2_q;
	logic [AW-1:0] low_q, j_q, j1_q, j2_q, jst_q;
	logic [NW-1:0] up_q;
	entry_t ent_q;
	logic signed [DATA_W:0] s_q;
	logic signed [WIDE_W-1:0] t_q;
	logic [1:0] k_q;
	logic signed [63:0] sum_q;

	logic [NW-1:0] n, nm2;
	logic [NW:0] mid_sum;
	logic [AW-1:0] mid, nlow, segc, raddr;
	logic [NW-1:0] nup;
	logic more, take;
	logic signed [DATA_W-1:0] x;
	entry_t rd_ent;
	logic mul_done, mul_ov;
	logic signed [WIDE_W-1:0] mul_p;
	logic signed [DATA_W-1:0] addend;
	logic signed [WIDE_W:0] hsum;
	logic signed [WIDE_W-1:0] tnew;
	logic tov;
	logic [DATA_W:0] m_cub, m_sq, m_sl;
	logic [63:0] p3;
	logic [DATA_W-1:0] q4, q3, q2;
	logic signed [DATA_W-1:0] base;
	logic signed [63:0] res64;
	logic signed [DATA_W-1:0] res32;
	logic rov;
	logic [IDX_W-1:0] seg_out;

	always_comb begin
		if (kc < KC_W'(MIN_KNOTS)) begin
			n = NW'(MIN_KNOTS);
		end else if (32'(kc) > 32'(MAX_KNOTS)) begin
			n = NW'(MAX_KNOTS);
		end else begin
			n = NW'(kc);
		end
		nm2 = n - NW'(MIN_KNOTS);
		mid_sum = (NW+1)'(low_q) + (NW+1)'(up_q);
		mid = mid_sum[AW:1];
		x = phase_q ? hi_q : lo_q;
		take = rd_ent.position <= x;
		nlow = take ? mid : low_q;
		nup = take ? up_q : NW'(mid);
		more = (NW+1)'(nup) > (NW+1)'(nlow) + (NW+1)'(1);
		segc = (NW'(nlow) > nm2) ? nm2[AW-1:0] : nlow;
	end

	always_comb begin
		case (state_q)
			ST_NRD: raddr = j_q + AW'(1);
			ST_ERD: raddr = j_q;
			default: raddr = mid;
		endcase
	end

	assign cmd_pop = (state_q == ST_IDLE) && cmd_valid;

	spl_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (MAX_KNOTS)
	) u_ram (
		.clk   (clk),
		.we    (cmd_pop && cmd.kind == K_LOAD),
		.waddr (AW'(cmd.idx)),
		.wdata (cmd.ent),
		.raddr (raddr),
		.rdata (rd_ent)
	);

	spl_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (go_q),
		.a      (s_q),
		.b      (t_q),
		.done   (mul_done),
		.p      (mul_p),
		.ov     (mul_ov)
	);

	// rounded halving, thirding and quartering of the coefficients
	always_comb begin
		m_cub = rd_ent.cubic[DATA_W-1] ? -{1'b1, rd_ent.cubic} : {1'b0, rd_ent.cubic};
		m_sq = rd_ent.square[DATA_W-1] ? -{1'b1, rd_ent.square} : {1'b0, rd_ent.square};
		m_sl = rd_ent.slope[DATA_W-1] ? -{1'b1, rd_ent.slope} : {1'b0, rd_ent.slope};
		q4 = DATA_W'((m_cub + (DATA_W+1)'(2)) >> 2);
		p3 = DATA_W'(m_sq + (DATA_W+1)'(1)) * RECIP3;
		q3 = DATA_W'(p3 >> 33);
		q2 = DATA_W'((m_sl + (DATA_W+1)'(1)) >> 1);
	end

	always_comb begin
		case (k_q)
			2'd0: addend = eval_q ? ent_q.square : sq3_q;
			2'd1: addend = eval_q ? ent_q.slope : sl2_q;
			default: addend = ent_q.value;
		endcase
		hsum = {{(WIDE_W+1-DATA_W){addend[DATA_W-1]}}, addend} + {mul_p[WIDE_W-1], mul_p};
		tov = 1'b0;
		if (hsum > $signed({2'b00, WIDE_MAG})) begin
			tnew = $signed({1'b0, WIDE_MAG});
			tov = 1'b1;
		end else if (hsum < -$signed({2'b00, WIDE_MAG})) begin
			tnew = -$signed({1'b0, WIDE_MAG});
			tov = 1'b1;
		end else begin
			tnew = hsum[WIDE_W-1:0];
		end
	end

	always_comb begin
		base = (j_q == j2_q) ? hi_q : npos_q;
		if (eval_q) begin
			res64 = 64'(t_q);
		end else begin
			res64 = flip_q ? -sum_q : sum_q;
		end
		rov = 1'b0;
		if (res64 > 64'sh7FFFFFFF) begin
			res32 = 32'sh7FFFFFFF;
			rov = 1'b1;
		end else if (res64 < -64'sh80000000) begin
			res32 = 32'sh80000000;
			rov = 1'b1;
		end else begin
			res32 = res64[DATA_W-1:0];
		end
		seg_out = eval_q ? IDX_W'(j_q) : IDX_W'(j2_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			go_q <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			go_q <= 1'b0;
			if (m_tvalid && m_tready) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_pop && cmd.kind != K_LOAD) begin
						state_q <= ST_SRD;
					end
				end
				ST_SRD: state_q <= ST_SCMP;
				ST_SCMP: begin
					if (more) begin
						state_q <= ST_SRD;
					end else if (eval_q) begin
						state_q <= ST_ERD;
					end else if (!phase_q) begin
						state_q <= ST_SRD;
					end else begin
						state_q <= ST_SEG;
					end
				end
				ST_SEG: state_q <= (j_q == j2_q) ? ST_ERD : ST_NRD;
				ST_NRD: state_q <= ST_NLAT;
				ST_NLAT: state_q <= ST_ERD;
				ST_ERD: state_q <= ST_ELAT;
				ST_ELAT: state_q <= ST_STRT;
				ST_STRT: begin
					go_q <= 1'b1;
					state_q <= ST_HRN;
				end
				ST_HRN: begin
					if (mul_done) begin
						if (k_q == 2'd2 && eval_q) begin
							state_q <= ST_FIN;
						end else if (k_q != 2'd3) begin
							go_q <= 1'b1;
						end else if (!term_q && j_q == jst_q) begin
							state_q <= ST_STRT;
						end else if (j_q == j2_q) begin
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_SEG;
						end
					end
				end
				ST_FIN: begin
					if (!m_tvalid || m_tready) begin
						m_tvalid <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				eval_q <= cmd.kind == K_EVAL;
				flip_q <= (cmd.kind == K_INTEG) && (cmd.q1 > cmd.q2);
				lo_q <= (cmd.kind == K_INTEG && cmd.q1 > cmd.q2) ? cmd.q2 : cmd.q1;
				hi_q <= (cmd.kind == K_INTEG && cmd.q1 > cmd.q2) ? cmd.q1 : cmd.q2;
				low_q <= '0;
				up_q <= n;
				phase_q <= 1'b0;
				ov_q <= 1'b0;
				sum_q <= '0;
			end
			ST_SCMP: begin
				low_q <= nlow;
				up_q <= nup;
				if (!more) begin
					low_q <= '0;
					up_q <= n;
					phase_q <= 1'b1;
					term_q <= 1'b0;
					j_q <= segc;
					if (!phase_q) begin
						j1_q <= segc;
					end else begin
						j2_q <= segc;
						jst_q <= (j1_q >= segc) ? segc : j1_q;
						j_q <= (j1_q >= segc) ? segc : j1_q;
					end
				end
			end
			ST_NLAT: npos_q <= rd_ent.position;
			ST_ELAT: begin
				ent_q <= rd_ent;
				cub4_q <= rd_ent.cubic[DATA_W-1] ? -q4 : q4;
				sq3_q <= rd_ent.square[DATA_W-1] ? -q3 : q3;
				sl2_q <= rd_ent.slope[DATA_W-1] ? -q2 : q2;
			end
			ST_STRT: begin
				k_q <= '0;
				if (eval_q || term_q) begin
					s_q <= {lo_q[DATA_W-1], lo_q} - {ent_q.position[DATA_W-1], ent_q.position};
				end else begin
					s_q <= {base[DATA_W-1], base} - {ent_q.position[DATA_W-1], ent_q.position};
				end
				t_q <= eval_q ? WIDE_W'(ent_q.cubic) : WIDE_W'(cub4_q);
			end
			ST_HRN: begin
				if (mul_done) begin
					ov_q <= ov_q | mul_ov | ((k_q != 2'd3) && tov);
					t_q <= tnew;
					k_q <= k_q + 2'd1;
					if (k_q == 2'd3) begin
						sum_q <= term_q ? sum_q - 64'(mul_p) : sum_q + 64'(mul_p);
						if (!term_q && j_q == jst_q) begin
							term_q <= 1'b1;
						end else begin
							term_q <= 1'b0;
							j_q <= j_q + AW'(1);
						end
					end
				end
			end
			ST_FIN: begin
				if (!m_tvalid || m_tready) begin
					m_tdata <= {7'b0, ov_q | rov, seg_out, res32};
				end
			end
			default: begin
				npos_q <= npos_q;
			end
		endcase
	end

endmodule

// ----- rtl/cubic_spline_table_evaluator.sv -----
// Piecewise cubic spline table evaluator. A load beat writes one knot entry
// (position, value, cubic, square and slope terms, all signed Q16.16);
// evaluate and integrate beats return one result beat each. Beats pass
// through a two-deep queue into a sequencer that owns a table with one write
// port and one registered read port, and one multiplier that works through
// three 16-bit digits and then a rounded result register for each product.
// An evaluate runs a binary search, with a table read and a compare per
// step, then three Horner products. An integrate runs two searches, then
// four products for each segment between the bounds and four more for the
// lower bound term. A result waits in the output register while the queue
// keeps taking beats until it is full. The table is not cleared at reset.
module cubic_spline_table_evaluator import spl_pkg::*; #(
	parameter int MAX_KNOTS = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// entry_index, knot_position, knot_value, cubic_term, square_term,
	// slope_term, query_point, upper_bound
	input  logic [S_TDATA_W-1:0] s_tdata,
	// operation
	input  logic [1:0]           s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// result_value, segment_found, overflowed, zero fill
	output logic [M_TDATA_W-1:0] m_tdata,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_W-1:0]    paddr,
	input  logic [DATA_W-1:0]    pwdata,
	output logic [DATA_W-1:0]    prdata,
	output logic                 pready
);

	logic [KC_W-1:0] knot_count_q;
	logic cmd_valid, cmd_pop;
	cmd_t cmd;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_KNOT_COUNT) ? DATA_W'(knot_count_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			knot_count_q <= KC_W'(MIN_KNOTS);
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_KNOT_COUNT) begin
			knot_count_q <= pwdata[KC_W-1:0];
		end
	end

	spl_front #(
		.MAX_KNOTS (MAX_KNOTS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	spl_back #(
		.MAX_KNOTS (MAX_KNOTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.kc        (knot_count_q),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

// ----- rtl/spl_check.sv -----
module spl_check import spl_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata,
	input logic                 psel,
	input logic                 penable,
	input logic                 pwrite,
	input logic [ADDR_W-1:0]    paddr,
	input logic [DATA_W-1:0]    pwdata,
	input logic [DATA_W-1:0]    prdata,
	input logic                 pready
);

	// a stalled result beat holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// fill bits above the overflow flag stay zero
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[M_TDATA_W-1:41] == '0)
		else $error("result fill bits not zero");

	// knot count reads back what was written
	assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && pready && paddr[2] == REG_KNOT_COUNT)
		##1 (psel && !pwrite && paddr[2] == REG_KNOT_COUNT)
		|-> prdata == {23'b0, $past(pwdata[KC_W-1:0])})
		else $error("knot count readback mismatch");

	// no result right out of reset
	assert property (@(posedge clk) $rose(arst_n) |-> !m_tvalid)
		else $error("result beat during reset");

endmodule

bind cubic_spline_table_evaluator spl_check u_spl_check (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.psel     (psel),
	.penable  (penable),
	.pwrite   (pwrite),
	.paddr    (paddr),
	.pwdata   (pwdata),
	.prdata   (prdata),
	.pready   (pready)
);

// ----- dv/tb.sv -----
module tb;
	import spl_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam longint WIDE_LIM = 64'h7FFF_FFFF_FFFF;
	localparam int STALL_LIMIT = 100000;

	typedef struct {
		logic [1:0]  op;
		logic [7:0]  idx;
		logic [31:0] p, v, c, s, l, q1, q2;
	} beat_t;

	class spline_scoreboard;
		typedef struct {
			logic [31:0] res;
			logic [7:0]  seg;
			logic        ov;
		} result_t;

		longint pos[256], val[256], cub[256], sq[256], sl[256];
		logic [8:0] knot_reg;
		bit ovf;
		int errors;
		result_t expected_q[$];

		function new();
			knot_reg = 9'd2;
			errors = 0;
		endfunction

		function void set_count(logic [31:0] v);
			knot_reg = v[8:0];
		endfunction

		function int unsigned active_n();
			if (knot_reg < 2) return 2;
			if (knot_reg > 256) return 256;
			return knot_reg;
		endfunction

		function longint clamp_wide(longint v);
			if (v > WIDE_LIM) begin
				ovf = 1;
				return WIDE_LIM;
			end
			if (v < -WIDE_LIM) begin
				ovf = 1;
				return -WIDE_LIM;
			end
			return v;
		endfunction

		// q16.16 product, rounded half away from zero
		function longint qmul(longint a, longint b);
			logic [127:0] p;
			logic [63:0] ua, ub;
			longint r;
			bit neg;
			neg = (a < 0) != (b < 0);
			ua = a < 0 ? -a : a;
			ub = b < 0 ? -b : b;
			p = {64'd0, ua} * {64'd0, ub};
			p = (p + 128'h8000) >> 16;
			if (p > 128'h7FFF_FFFF_FFFF) begin
				ovf = 1;
				r = WIDE_LIM;
			end else begin
				r = longint'(p[63:0]);
			end
			return neg ? -r : r;
		endfunction

		function longint div_round(longint v, longint k);
			longint m, q;
			m = v < 0 ? -v : v;
			q = (m + k / 2) / k;
			return v < 0 ? -q : q;
		endfunction

		function int unsigned locate(longint x, int unsigned n);
			int unsigned lo, up, mid;
			lo = 0;
			up = n;
			do begin
				mid = (lo + up) / 2;
				if (pos[mid] <= x) lo = mid;
				else up = mid;
			end while (up > lo + 1);
			return lo > n - 2 ? n - 2 : lo;
		endfunction

		function longint horner(int unsigned j, longint s);
			longint t;
			t = cub[j];
			t = clamp_wide(sq[j] + qmul(s, t));
			t = clamp_wide(sl[j] + qmul(s, t));
			return clamp_wide(val[j] + qmul(s, t));
		endfunction

		function longint antideriv(int unsigned j, longint s);
			longint t;
			t = div_round(cub[j], 4);
			t = clamp_wide(div_round(sq[j], 3) + qmul(s, t));
			t = clamp_wide(div_round(sl[j], 2) + qmul(s, t));
			t = clamp_wide(val[j] + qmul(s, t));
			return qmul(s, t);
		endfunction

		function void note_beat(logic [1:0] op, logic [S_TDATA_W-1:0] d);
			int unsigned n, seg, j1, j2, e;
			longint q1, q2, tmp, sum, res;
			bit flip;
			result_t r;
			n = active_n();
			q1 = longint'($signed(d[199:168]));
			q2 = longint'($signed(d[231:200]));
			ovf = 0;
			case (op)
				OP_LOAD: begin
					e = d[7:0];
					pos[e] = longint'($signed(d[39:8]));
					val[e] = longint'($signed(d[71:40]));
					cub[e] = longint'($signed(d[103:72]));
					sq[e] = longint'($signed(d[135:104]));
					sl[e] = longint'($signed(d[167:136]));
					return;
				end
				OP_EVAL: begin
					seg = locate(q1, n);
					res = horner(seg, q1 - pos[seg]);
				end
				OP_INTEG: begin
					flip = q1 > q2;
					if (flip) begin
						tmp = q1;
						q1 = q2;
						q2 = tmp;
					end
					j1 = locate(q1, n);
					j2 = locate(q2, n);
					if (j1 >= j2) begin
						sum = antideriv(j2, q2 - pos[j2]) - antideriv(j2, q1 - pos[j2]);
					end else begin
						sum = antideriv(j1, pos[j1 + 1] - pos[j1]) - antideriv(j1, q1 - pos[j1]);
						for (int unsigned j = j1 + 1; j < j2; j++)
							sum += antideriv(j, pos[j + 1] - pos[j]);
						sum += antideriv(j2, q2 - pos[j2]);
					end
					res = flip ? -sum : sum;
					seg = j2;
				end
				default: return;
			endcase
			if (res > 64'sh7FFF_FFFF) begin
				ovf = 1;
				res = 64'sh7FFF_FFFF;
			end else if (res < -64'sh8000_0000) begin
				ovf = 1;
				res = -64'sh8000_0000;
			end
			r.res = res[31:0];
			r.seg = seg[7:0];
			r.ov = ovf;
			expected_q.push_back(r);
		endfunction

		function void check_beat(logic [M_TDATA_W-1:0] d);
			result_t r;
			if (expected_q.size() == 0) begin
				$error("result beat with nothing expected: %h", d);
				errors++;
				return;
			end
			r = expected_q.pop_front();
			if (d[31:0] !== r.res) begin
				$error("result_value expected %0d got %0d", $signed(r.res), $signed(d[31:0]));
				errors++;
			end
			if (d[39:32] !== r.seg) begin
				$error("segment_found expected %0d got %0d", r.seg, d[39:32]);
				errors++;
			end
			if (d[40] !== r.ov) begin
				$error("overflowed expected %0d got %0d", r.ov, d[40]);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic s_tvalid, s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic [1:0] s_tuser;
	logic m_tvalid, m_tready;
	logic [M_TDATA_W-1:0] m_tdata;
	logic psel, penable, pwrite, pready;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata, prdata;

	spline_scoreboard sb;
	int tx_idle, rx_idle;
	int hold_left;
	bit hold_req;
	int stall_cnt;
	longint gen_pos[256];
	bit written[256];

	cubic_spline_table_evaluator u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial clk = 0;
	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	always @(posedge clk) begin
		if (s_tvalid && s_tready) sb.note_beat(s_tuser, s_tdata);
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready) sb.check_beat(m_tdata);
		if (hold_req) begin
			hold_left = 400;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
			stall_cnt = 0;
		else
			stall_cnt++;
		if (stall_cnt >= STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic logic [31:0] sat32(longint v);
		if (v > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
		if (v < -64'sh8000_0000) return 32'h8000_0000;
		return v[31:0];
	endfunction

	function automatic beat_t mk(logic [1:0] op, logic [7:0] idx, logic [31:0] p, v, c, s, l,
			q1, q2);
		beat_t b;
		b.op = op; b.idx = idx; b.p = p; b.v = v; b.c = c; b.s = s; b.l = l;
		b.q1 = q1; b.q2 = q2;
		return b;
	endfunction

	function automatic logic [31:0] rnd_coef();
		int r;
		r = $urandom_range(9);
		if (r < 5) return $urandom_range(32'h3FFFF) - 32'h20000;
		if (r < 8) return $urandom_range(32'h3FFFFF) - 32'h200000;
		return $urandom;
	endfunction

	function automatic logic [31:0] gen_query(int unsigned n);
		int r;
		int unsigned k;
		longint d, v;
		r = $urandom_range(99);
		k = $urandom_range(n - 2);
		if (r < 50) begin
			d = gen_pos[k + 1] - gen_pos[k];
			v = d > 0 ? gen_pos[k] + longint'($urandom) % d : gen_pos[k];
		end else if (r < 65) begin
			v = gen_pos[$urandom_range(n - 1)];
		end else if (r < 80) begin
			d = $urandom_range(32'h3FFFFF);
			v = $urandom_range(1) ? gen_pos[0] - d : gen_pos[n - 1] + d;
		end else if (r < 95) begin
			v = longint'($signed(32'($urandom)));
		end else begin
			v = $urandom_range(1) ? 64'sh7FFF_FFFF : -64'sh8000_0000;
		end
		return sat32(v);
	endfunction

	task automatic send(beat_t b);
		if ($urandom_range(99) < tx_idle) begin
			s_tvalid <= 0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {b.q2, b.q1, b.l, b.s, b.c, b.v, b.p, b.idx};
		s_tuser <= b.op;
		if (b.op == OP_LOAD) begin
			written[b.idx] = 1;
			gen_pos[b.idx] = longint'($signed(b.p));
		end
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic quiet();
		s_tvalid <= 0;
		@(posedge clk);
	endtask

	// wait out all results, then let queued loads settle
	task automatic drain();
		quiet();
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic reg_write(logic [31:0] data);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {REG_KNOT_COUNT, 2'b00};
		pwdata <= {23'($urandom), data[8:0]};
		@(posedge clk);
		penable <= 1;
		do @(posedge clk); while (!pready);
		psel <= 0;
		penable <= 0;
		sb.set_count(data);
	endtask

	task automatic load_table(int unsigned n, bit full);
		longint spacing, base, p;
		spacing = longint'(1) << $urandom_range(4, 23);
		base = -(spacing * longint'(n)) / 2;
		for (int unsigned i = 0; i < n; i++) begin
			if (full || i < 16 || !written[i]) begin
				p = base + i * spacing + longint'($urandom_range(spacing / 2));
				send(mk(OP_LOAD, i, sat32(p), rnd_coef(), rnd_coef(), rnd_coef(), rnd_coef(),
					$urandom, $urandom));
			end
		end
	endtask

	task automatic run_random(int unsigned n, int count);
		int r;
		logic [7:0] idx;
		logic [31:0] p;
		for (int k = 0; k < count; k++) begin
			r = $urandom_range(99);
			if (r < 45) begin
				send(mk(OP_EVAL, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
					gen_query(n), $urandom));
			end else if (r < 85) begin
				send(mk(OP_INTEG, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
					gen_query(n), gen_query(n)));
			end else if (r < 95) begin
				idx = $urandom_range(9) == 0 ? $urandom_range(255) : $urandom_range(n - 1);
				p = ($urandom_range(9) < 7 && written[idx]) ? gen_pos[idx][31:0] : $urandom;
				send(mk(OP_LOAD, idx, p, rnd_coef(), rnd_coef(), rnd_coef(), rnd_coef(),
					$urandom, $urandom));
			end else begin
				send(mk(OP_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom));
			end
		end
	endtask

	task automatic set_mode(int mode);
		case (mode)
			0: begin
				tx_idle = 22;
				rx_idle = 82;
			end
			1: begin
				tx_idle = 82;
				rx_idle = 22;
			end
			default: begin
				tx_idle = 0;
				rx_idle = 0;
			end
		endcase
	endtask

	task automatic run_phase(logic [31:0] cfg, int items, int mode, bit full);
		drain();
		set_mode(mode);
		reg_write(cfg);
		load_table(sb.active_n(), full);
		run_random(sb.active_n(), items);
	endtask

	task automatic directed();
		logic [31:0] lo, hi, mn, mx;
		lo = gen_pos[0][31:0];
		hi = gen_pos[3][31:0];
		mn = 32'h8000_0000;
		mx = 32'h7FFF_FFFF;
		send(mk(OP_EVAL, 0, 0, 0, 0, 0, 0, lo, 0));
		send(mk(OP_EVAL, 0, 0, 0, 0, 0, 0, sat32((gen_pos[1] + gen_pos[2]) / 2), 0));
		send(mk(OP_EVAL, 0, 0, 0, 0, 0, 0, mn, 0));
		send(mk(OP_EVAL, 0, 0, 0, 0, 0, 0, mx, 0));
		send(mk(OP_EVAL, 0, 0, 0, 0, 0, 0, hi, 0));
		send(mk(OP_INTEG, 0, 0, 0, 0, 0, 0, lo, hi));
		send(mk(OP_INTEG, 0, 0, 0, 0, 0, 0, hi, lo));
		send(mk(OP_INTEG, 0, 0, 0, 0, 0, 0, lo, lo));
		send(mk(OP_INTEG, 0, 0, 0, 0, 0, 0, mn, mx));
		send(mk(OP_UNUSED, 8'hFF, mx, mx, mx, mx, mx, mx, mx));
		// saturating coefficients
		send(mk(OP_LOAD, 1, gen_pos[1][31:0], mx, mx, mx, mx, 0, 0));
		send(mk(OP_EVAL, 0, 0, 0, 0, 0, 0, gen_pos[2][31:0], 0));
		send(mk(OP_INTEG, 0, 0, 0, 0, 0, 0, lo, hi));
		send(mk(OP_LOAD, 2, gen_pos[2][31:0], mn, mn, mn, mn, 0, 0));
		send(mk(OP_EVAL, 0, 0, 0, 0, 0, 0, mx, 0));
		send(mk(OP_INTEG, 0, 0, 0, 0, 0, 0, mx, mn));
		send(mk(OP_LOAD, 8'hFF, mx, mx, mx, mx, mx, mx, mx));
		send(mk(OP_LOAD, 8'hFE, mn, mn, mn, mn, mn, mn, mn));
	endtask

	initial begin
		sb = new();
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = '0;
		pwdata = '0;
		hold_left = 0;
		hold_req = 0;
		stall_cnt = 0;
		set_mode(0);
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		reg_write(4);
		load_table(4, 1);
		directed();
		run_random(4, 20);

		run_phase(2, 20, 0, 0);
		run_phase(0, 10, 0, 0);
		// receiver holds off while beats keep coming
		hold_req = 1;
		run_random(sb.active_n(), 20);

		run_phase(8, 30, 1, 0);
		run_phase(256, 10, 1, 1);
		run_phase(3, 15, 1, 0);
		drain();
		run_random(sb.active_n(), 15);

		run_phase(511, 8, 2, 0);
		run_phase(16, 30, 2, 0);
		run_phase(1, 10, 2, 0);
		run_phase(6, 20, 2, 0);

		drain();
		if (sb.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ----- cubic_spline_table_evaluator.f -----
rtl/spl_pkg.sv
rtl/spl_ram.sv
rtl/spl_mul.sv
rtl/spl_front.sv
rtl/spl_back.sv
rtl/cubic_spline_table_evaluator.sv
rtl/spl_check.sv
dv/tb.sv
